>>> rtl/hzc_pkg.sv
// ============================================================================
// hzc_pkg: shared types and constants for the HZ-order address converter
// Field widths, register and opcode codes, axis codes, and the structs that
// carry items, results and configuration status between modules.
// ============================================================================
package hzc_pkg;

  // Fixed field widths
  localparam int COORD_W    = 31;
  localparam int HZ_W       = 63;
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SYM_LOW_W  = 64;
  localparam int SYM_HIGH_W = 62;
  localparam int AXIS_W     = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOLS_LOW   = 2'd0,
    REG_SYMBOLS_HIGH  = 2'd1,
    REG_STRING_LENGTH = 2'd2
  } cfg_reg_t;

  // Operations
  typedef enum logic {
    OP_TO_HZ    = 1'b0,
    OP_TO_COORD = 1'b1
  } opcode_t;

  // Axis symbol codes; the last one is illegal
  localparam logic [AXIS_W-1:0] AXIS_X       = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y       = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z       = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_INVALID = 2'd3;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  typedef struct packed {
    opcode_t            opcode;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [HZ_W-1:0]    hz_address;
  } hzc_item_t;

  typedef struct packed {
    logic [HZ_W-1:0]    hz_address;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [LEN_W-1:0]   level;
    logic               error;
  } hzc_result_t;

  // Derived configuration status
  typedef struct packed {
    logic             ok;     // symbol table matches the registers
    logic             error;  // empty string or illegal symbol in use
    logic [LEN_W-1:0] len;    // saturated string length
  } hzc_cfg_status_t;

endpackage

>>> rtl/hzc_cfg.sv
// ============================================================================
// hzc_cfg: configuration registers and symbol table
// Holds the symbol string and its length, and keeps a registered table that
// gives, for each Z-address bit from the LSB, its axis and its bit rank
// within that axis.
// ============================================================================
module hzc_cfg #(
  parameter int MAX_SYMBOLS = 63,
  parameter int RANK_W      = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hzc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hzc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hzc_pkg::hzc_cfg_status_t         status,
  output logic [hzc_pkg::AXIS_W-1:0]       axis [MAX_SYMBOLS],
  output logic [RANK_W-1:0]                rank [MAX_SYMBOLS],
  output logic [MAX_SYMBOLS-1:0]           live
);
  import hzc_pkg::*;

  localparam int STR_W = AXIS_W * MAX_SYMBOLS;

  logic [SYM_LOW_W-1:0]             symbols_low;
  logic [SYM_HIGH_W-1:0]            symbols_high;
  logic [LEN_W-1:0]                 string_length;
  logic                             ok;
  logic                             cfg_error;
  logic [LEN_W-1:0]                 len;

  logic [SYM_HIGH_W+SYM_LOW_W-1:0]  sym_str;
  logic [LEN_W-1:0]                 len_eff;
  logic [LEN_W-1:0]                 gap;
  logic [STR_W-1:0]                 rev;
  logic [STR_W-1:0]                 rsym_vec;
  logic [AXIS_W-1:0]                rsym [MAX_SYMBOLS];
  logic [RANK_W-1:0]                rank_c [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0]           live_c;
  logic [MAX_SYMBOLS-1:0]           bad;
  logic                             err_c;

  // Register writes; the table is stale after a write or reset, and ok is low while it is
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low   <= '0;
      symbols_high  <= '0;
      string_length <= LEN_RESET;
      ok            <= 1'b0;
    end else begin
      ok <= !cfg_write;
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SYMBOLS_LOW:   symbols_low   <= cfg_data;
          REG_SYMBOLS_HIGH:  symbols_high  <= cfg_data[SYM_HIGH_W-1:0];
          REG_STRING_LENGTH: string_length <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Saturate length; reverse the string so entry r is Z-address bit r
  always_comb begin
    sym_str = {symbols_high, symbols_low};
    len_eff = (string_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : string_length;
    gap     = LEN_W'(MAX_SYMBOLS) - len_eff;
    for (int q = 0; q < MAX_SYMBOLS; q++) begin
      rev[AXIS_W*q +: AXIS_W] = sym_str[AXIS_W*(MAX_SYMBOLS-1-q) +: AXIS_W];
    end
    rsym_vec = rev >> {gap, 1'b0};
    for (int r = 0; r < MAX_SYMBOLS; r++) begin
      rsym[r]   = rsym_vec[AXIS_W*r +: AXIS_W];
      live_c[r] = LEN_W'(r) < len_eff;
      bad[r]    = rsym[r] == AXIS_INVALID;
    end
    err_c = (len_eff == '0) || |(bad & live_c);
  end

  // Rank: how many lower bits use the same axis
  always_comb begin
    logic [MAX_SYMBOLS-1:0] same;
    for (int r = 0; r < MAX_SYMBOLS; r++) begin
      same = '0;
      for (int q = 0; q < r; q++) begin
        same[q] = rsym[q] == rsym[r];
      end
      rank_c[r] = RANK_W'($countones(same));
    end
  end

  // Registered table
  always_ff @(posedge clk) begin
    axis      <= rsym;
    rank      <= rank_c;
    live      <= live_c;
    cfg_error <= err_c;
    len       <= len_eff;
  end

  assign status = '{ok: ok, error: cfg_error, len: len};

endmodule

>>> rtl/hzc_datapath.sv
// ============================================================================
// hzc_datapath: one-pass conversion logic
// Interleaves coordinates into an HZ address, or decodes an HZ address back
// to coordinates, from the registered symbol table.
// ============================================================================
module hzc_datapath #(
  parameter int MAX_SYMBOLS = 63,
  parameter int COORD_BITS  = 31,
  parameter int RANK_W      = 6
) (
  input  hzc_pkg::hzc_item_t               item,
  input  hzc_pkg::hzc_cfg_status_t         status,
  input  logic [hzc_pkg::AXIS_W-1:0]       axis [MAX_SYMBOLS],
  input  logic [RANK_W-1:0]                rank [MAX_SYMBOLS],
  input  logic [MAX_SYMBOLS-1:0]           live,
  output hzc_pkg::hzc_result_t             result
);
  import hzc_pkg::*;

  localparam int ZW     = MAX_SYMBOLS + 1;
  localparam int EFF_CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int KN     = (EFF_CB < (2 ** RANK_W)) ? EFF_CB : (2 ** RANK_W);

  logic [ZW-1:0]          z_enc;
  logic [ZW-1:0]          z_mark;
  logic [LEN_W-1:0]       tz;
  logic [ZW-1:0]          hz_enc;
  logic [LEN_W-1:0]       lvl_enc;

  logic [MAX_SYMBOLS-1:0] hz_m;
  logic [LEN_W-1:0]       lvl_dec;
  logic [LEN_W-1:0]       zl;
  logic [ZW-1:0]          z_dec;
  logic [COORD_W-1:0]     dec_x;
  logic [COORD_W-1:0]     dec_y;
  logic [COORD_W-1:0]     dec_z;

  // Encode: gather coordinate bits, add marker, strip trailing zeros and the lowest one
  always_comb begin
    logic [COORD_W-1:0] src;
    logic               pick;
    z_enc = '0;
    for (int r = 0; r < MAX_SYMBOLS; r++) begin
      unique case (axis[r])
        AXIS_X:  src = item.coord_x;
        AXIS_Y:  src = item.coord_y;
        AXIS_Z:  src = item.coord_z;
        default: src = '0;
      endcase
      pick = 1'b0;
      for (int k = 0; k < KN; k++) begin
        if (rank[r] == RANK_W'(k)) pick = src[k];
      end
      z_enc[r] = live[r] & pick;
    end
    z_mark = z_enc | (ZW'(1) << status.len);
    tz = '0;
    for (int i = ZW - 1; i >= 0; i--) begin
      if (z_mark[i]) tz = LEN_W'(i);
    end
    hz_enc  = (z_mark >> 1) >> tz;
    lvl_enc = status.len - tz;
  end

  // Decode: find level, rebuild Z address, scatter bits to axes
  always_comb begin
    hz_m    = item.hz_address[MAX_SYMBOLS-1:0] & live;
    lvl_dec = '0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (hz_m[i]) lvl_dec = LEN_W'(i + 1);
    end
    zl    = status.len - lvl_dec;
    z_dec = {hz_m, 1'b1} << zl;
    dec_x = '0;
    dec_y = '0;
    dec_z = '0;
    for (int r = 0; r < MAX_SYMBOLS; r++) begin
      for (int k = 0; k < KN; k++) begin
        if (live[r] && z_dec[r] && rank[r] == RANK_W'(k)) begin
          unique case (axis[r])
            AXIS_X:  dec_x[k] = 1'b1;
            AXIS_Y:  dec_y[k] = 1'b1;
            AXIS_Z:  dec_z[k] = 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  // Result select; a bad configuration zeroes everything but the flag
  always_comb begin
    result = '0;
    if (status.error) begin
      result.error = 1'b1;
    end else if (item.opcode == OP_TO_HZ) begin
      result.hz_address = HZ_W'(hz_enc);
      result.coord_x    = item.coord_x;
      result.coord_y    = item.coord_y;
      result.coord_z    = item.coord_z;
      result.level      = lvl_enc;
    end else begin
      result.hz_address = item.hz_address;
      result.coord_x    = dec_x;
      result.coord_y    = dec_y;
      result.coord_z    = dec_z;
      result.level      = lvl_dec;
    end
  end

endmodule

>>> rtl/hz_order_address_convert_core.sv
// ============================================================================
// hz_order_address_convert_core: HZ-order address converter
// Accepts one item per cycle unless an output stall or a stale symbol table
// holds the input register. An accepted item waits in the input register
// and passes through the conversion logic into the output register when it
// advances; its result stays on the outputs until the output side takes it.
// The throughput is one item per clock while nothing stalls, set by that
// single registered pass. After every configuration write the registered
// symbol table (axis and bit rank of each address bit) is rebuilt at the next
// edge, and an item in the input register is held until then. After reset the
// table is ready before the first item reaches the conversion logic, so no
// item waits.
// ============================================================================
module hz_order_address_convert_core #(
  parameter int MAX_SYMBOLS = 63,
  parameter int COORD_BITS  = 31
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hzc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hzc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [hzc_pkg::COORD_W-1:0]     in_coord_x,
  input  logic [hzc_pkg::COORD_W-1:0]     in_coord_y,
  input  logic [hzc_pkg::COORD_W-1:0]     in_coord_z,
  input  logic [hzc_pkg::HZ_W-1:0]        in_hz_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hzc_pkg::HZ_W-1:0]        out_hz_address,
  output logic [hzc_pkg::COORD_W-1:0]     out_coord_x,
  output logic [hzc_pkg::COORD_W-1:0]     out_coord_y,
  output logic [hzc_pkg::COORD_W-1:0]     out_coord_z,
  output logic [hzc_pkg::LEN_W-1:0]       out_level,
  output logic                            out_error
);
  import hzc_pkg::*;

  localparam int RANK_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  hzc_cfg_status_t        status;
  logic [AXIS_W-1:0]      axis [MAX_SYMBOLS];
  logic [RANK_W-1:0]      rank [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] live;

  logic                   item_valid;
  hzc_item_t              item;
  hzc_result_t            result;
  hzc_result_t            result_q;
  logic                   adv;
  logic                   in_take;

  hzc_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .RANK_W      (RANK_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .axis      (axis),
    .rank      (rank),
    .live      (live)
  );

  hzc_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COORD_BITS  (COORD_BITS),
    .RANK_W      (RANK_W)
  ) u_datapath (
    .item   (item),
    .status (status),
    .axis   (axis),
    .rank   (rank),
    .live   (live),
    .result (result)
  );

  // Handshake: input register moves on when the table is current and the
  // output register is free or being emptied
  assign adv      = item_valid && status.ok && (!out_valid || !out_stall);
  assign in_stall = item_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{opcode: opcode_t'(opcode), coord_x: in_coord_x, coord_y: in_coord_y,
                coord_z: in_coord_z, hz_address: in_hz_address};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_q <= result;
    end
  end

  assign out_hz_address = result_q.hz_address;
  assign out_coord_x    = result_q.coord_x;
  assign out_coord_y    = result_q.coord_y;
  assign out_coord_z    = result_q.coord_z;
  assign out_level      = result_q.level;
  assign out_error      = result_q.error;

endmodule

>>> rtl/hzc_checker.sv
// ============================================================================
// hzc_checker: port-level checks for the HZ-order address converter
// Watches the top-level ports for output hold, reset behavior, error result
// form and full input rate.
// ============================================================================
module hzc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_write,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [hzc_pkg::HZ_W-1:0]        out_hz_address,
  input logic [hzc_pkg::COORD_W-1:0]     out_coord_x,
  input logic [hzc_pkg::COORD_W-1:0]     out_coord_y,
  input logic [hzc_pkg::COORD_W-1:0]     out_coord_z,
  input logic [hzc_pkg::LEN_W-1:0]       out_level,
  input logic                            out_error
);
  import hzc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_hz_address) &&
      $stable(out_coord_x) && $stable(out_coord_y) && $stable(out_coord_z) &&
      $stable(out_level) && $stable(out_error))
    else $error("stalled result changed");

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("item left after reset");

  // Error result carries nothing but the flag
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_hz_address == '0 && out_coord_x == '0 &&
      out_coord_y == '0 && out_coord_z == '0 && out_level == '0)
    else $error("error result not cleared");

  // With the table current and the output draining, input never stalls
  a_full_rate: assert property (@(posedge clk) disable iff (rst)
    !out_stall && !$past(cfg_write) && !$past(rst) |-> !in_stall)
    else $error("input stalled without cause");

endmodule

bind hz_order_address_convert_core hzc_checker u_hzc_checker (.*);

>>> tb/sv/tb_hz_order_address_convert_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_hz_order_address_convert_core: self-checking bench for the HZ converter
// Streams conversion items in both directions through the core under a series
// of symbol strings, with random idle and stall bursts on both channels. Each
// accepted item is converted by a local model of the block and every result
// is compared field by field with the oldest prediction.
// ============================================================================
module tb_hz_order_address_convert_core;
  import hzc_pkg::*;

  localparam int MAX_SYMS  = 63;
  localparam int CRD_BITS  = COORD_W;
  localparam int TBL_W     = SYM_LOW_W + SYM_HIGH_W;
  localparam int RUN_LIMIT = 400000;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 136;

  typedef enum int {TBL_MIXED, TBL_SKEWED, TBL_CYCLIC, TBL_SINGLE} table_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = 1'b0;
  logic [COORD_W-1:0]    in_coord_x = '0;
  logic [COORD_W-1:0]    in_coord_y = '0;
  logic [COORD_W-1:0]    in_coord_z = '0;
  logic [HZ_W-1:0]       in_hz_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [HZ_W-1:0]       out_hz_address;
  logic [COORD_W-1:0]    out_coord_x;
  logic [COORD_W-1:0]    out_coord_y;
  logic [COORD_W-1:0]    out_coord_z;
  logic [LEN_W-1:0]      out_level;
  logic                  out_error;

  hz_order_address_convert_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_hz_address(in_hz_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hz_address(out_hz_address), .out_coord_x(out_coord_x),
    .out_coord_y(out_coord_y), .out_coord_z(out_coord_z),
    .out_level(out_level), .out_error(out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the configuration registers
  logic [TBL_W-1:0] sym_table = '0;
  logic [LEN_W-1:0] sym_count = LEN_RESET;

  hzc_item_t   todo_q[$];
  hzc_result_t expect_q[$];
  int          in_gap = 0;
  int          out_gap = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  bit          calm = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;

  function automatic logic [AXIS_W-1:0] axis_at(int pos);
    return sym_table[AXIS_W*pos +: AXIS_W];
  endfunction

  function automatic int bit_length(logic [63:0] v);
    int n;
    n = 0;
    for (int b = 0; b < 64; b++) if (v[b]) n = b + 1;
    return n;
  endfunction

  // Expected result of one item under the current string
  function automatic hzc_result_t convert_item(hzc_item_t it);
    hzc_result_t        r;
    int                 n, k, tz, lvl, zl;
    int                 used[3];
    logic               bad;
    logic [AXIS_W-1:0]  s;
    logic [COORD_W-1:0] c[3];
    logic [63:0]        z, hz;
    r = '0;
    n = (sym_count > MAX_SYMS) ? MAX_SYMS : int'(sym_count);
    bad = (n == 0);
    for (int i = 0; i < n; i++) if (axis_at(i) == AXIS_INVALID) bad = 1'b1;
    if (bad) begin
      r.error = 1'b1;
      return r;
    end
    if (it.opcode == OP_TO_HZ) begin
      // interleave: address bit i comes from symbol n-1-i
      c[0] = it.coord_x;
      c[1] = it.coord_y;
      c[2] = it.coord_z;
      used = '{0, 0, 0};
      z = '0;
      for (int i = 0; i < n; i++) begin
        s = axis_at(n - 1 - i);
        k = used[s];
        used[s]++;
        if (k < CRD_BITS) z[i] = c[s][k];
      end
      z[n] = 1'b1;
      tz = 0;
      while (!z[tz]) tz++;
      hz = z >> (tz + 1);
      r.hz_address = hz[HZ_W-1:0];
      r.coord_x = it.coord_x;
      r.coord_y = it.coord_y;
      r.coord_z = it.coord_z;
      r.level = LEN_W'(bit_length(hz));
    end else begin
      // rebuild the Z address and walk it from the top symbol down
      hz = {1'b0, it.hz_address} & ((64'd1 << n) - 64'd1);
      lvl = bit_length(hz);
      zl = n - lvl;
      z = (hz == 0) ? (64'd1 << n) : ((hz << (zl + 1)) | (64'd1 << zl));
      c = '{default: '0};
      for (int i = 0; i < n; i++) begin
        s = axis_at(i);
        c[s] = {c[s][COORD_W-2:0], z[n-1-i]};
      end
      r.hz_address = it.hz_address;
      r.coord_x = c[AXIS_X];
      r.coord_y = c[AXIS_Y];
      r.coord_z = c[AXIS_Z];
      r.level = LEN_W'(lvl);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= 50)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Input side: predict on acceptance, then present the next item or idle
  always @(posedge clk) begin
    hzc_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.opcode = opcode_t'(opcode);
        it.coord_x = in_coord_x;
        it.coord_y = in_coord_y;
        it.coord_z = in_coord_z;
        it.hz_address = in_hz_address;
        expect_q.push_back(convert_item(it));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (todo_q.size() > 0 && !calm && $urandom_range(99) < in_idle_pct) begin
          in_gap = $urandom_range(19, 1) - 1;
          in_valid <= 1'b0;
        end else if (todo_q.size() > 0) begin
          it = todo_q.pop_front();
          opcode <= it.opcode;
          in_coord_x <= it.coord_x;
          in_coord_y <= it.coord_y;
          in_coord_z <= it.coord_z;
          in_hz_address <= it.hz_address;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted result, then decide the next stall
  always @(posedge clk) begin
    hzc_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_hz_address), '0);
        end else begin
          want = expect_q.pop_front();
          if (out_hz_address !== want.hz_address)
            report_mismatch("hz_address", 64'(out_hz_address), 64'(want.hz_address));
          if (out_coord_x !== want.coord_x)
            report_mismatch("coord_x", 64'(out_coord_x), 64'(want.coord_x));
          if (out_coord_y !== want.coord_y)
            report_mismatch("coord_y", 64'(out_coord_y), 64'(want.coord_y));
          if (out_coord_z !== want.coord_z)
            report_mismatch("coord_z", 64'(out_coord_z), 64'(want.coord_z));
          if (out_level !== want.level)
            report_mismatch("level", 64'(out_level), 64'(want.level));
          if (out_error !== want.error)
            report_mismatch("error", 64'(out_error), 64'(want.error));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < out_idle_pct) begin
        out_gap = $urandom_range(19, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Block until every queued item has been converted and checked
  task automatic wait_drained();
    do @(negedge clk); while (todo_q.size() != 0 || in_valid || expect_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SYMBOLS_LOW:   sym_table[SYM_LOW_W-1:0] = val;
      REG_SYMBOLS_HIGH:  sym_table[TBL_W-1:SYM_LOW_W] = val[SYM_HIGH_W-1:0];
      REG_STRING_LENGTH: sym_count = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Loads a new string once the core is idle; junk above the high and length registers' widths
  task automatic load_table(logic [TBL_W-1:0] t, int len);
    wait_drained();
    write_reg(REG_SYMBOLS_LOW, t[SYM_LOW_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, {2'($urandom_range(3)), t[TBL_W-1:SYM_LOW_W]});
    write_reg(REG_STRING_LENGTH, {$urandom, 26'($urandom), 6'(len)});
  endtask

  function automatic logic [TBL_W-1:0] fill_table(table_mode_t mode);
    logic [TBL_W-1:0]  t;
    logic [AXIS_W-1:0] a;
    t = '0;
    a = 2'($urandom_range(2));
    for (int p = 0; p < MAX_SYMS; p++) begin
      case (mode)
        TBL_SKEWED: t[AXIS_W*p +: AXIS_W] =
                      ($urandom_range(9) < 8) ? a : 2'($urandom_range(2));
        TBL_CYCLIC: t[AXIS_W*p +: AXIS_W] = 2'(p % 3);
        TBL_SINGLE: t[AXIS_W*p +: AXIS_W] = a;
        default:    t[AXIS_W*p +: AXIS_W] = 2'($urandom_range(2));
      endcase
    end
    return t;
  endfunction

  function automatic hzc_item_t make_item(opcode_t op, logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                          logic [HZ_W-1:0] a);
    hzc_item_t it;
    it.opcode = op;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.hz_address = a;
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return COORD_W'($urandom_range(15));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly addresses that fit the string, with a spread of levels
  function automatic logic [HZ_W-1:0] rand_hz(int len);
    logic [63:0] v;
    int          lvl;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = '0;
      1: ; // random bits above the string are kept
      default: begin
        lvl = $urandom_range(len, 0);
        v = v & ((64'd1 << lvl) - 64'd1);
      end
    endcase
    return v[HZ_W-1:0];
  endfunction

  initial begin
    logic [TBL_W-1:0] tbl;
    int               len;
    int               p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset string: one x symbol
    todo_q.push_back(make_item(OP_TO_HZ, '0, '0, '0, '0));
    todo_q.push_back(make_item(OP_TO_HZ, '1, '1, '1, '1));
    todo_q.push_back(make_item(OP_TO_COORD, '1, '1, '1, '0));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, '1));

    // full-length repeating x y z string
    load_table(fill_table(TBL_CYCLIC), MAX_SYMS);
    todo_q.push_back(make_item(OP_TO_HZ, '0, '0, '0, '1));
    todo_q.push_back(make_item(OP_TO_HZ, '1, '1, '1, '0));
    todo_q.push_back(make_item(OP_TO_HZ, '1, '0, 31'h5555_5555, '0));
    todo_q.push_back(make_item(OP_TO_COORD, '1, '1, '1, '0));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, 63'd1));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, '1));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, 63'd1 << 62));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, 63'h1234_5678_9abc));

    // short string: address bits above it are ignored
    load_table(fill_table(TBL_CYCLIC), 10);
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, '1));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, (63'd1 << 40) | 63'd5));
    todo_q.push_back(make_item(OP_TO_HZ, '1, '1, '1, '0));

    // one axis over the whole string: coordinate bits past 31 read as zero
    load_table({TBL_W{1'b0}}, MAX_SYMS);
    todo_q.push_back(make_item(OP_TO_HZ, '1, '0, '0, '0));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, '1));
    load_table({(TBL_W/2){AXIS_Z}}, MAX_SYMS);
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, '1));
    todo_q.push_back(make_item(OP_TO_HZ, '0, '0, '1, '0));

    // illegal symbol past the end of the string is not examined
    tbl = fill_table(TBL_CYCLIC);
    tbl[AXIS_W*7 +: AXIS_W] = AXIS_INVALID;
    load_table(tbl, 5);
    todo_q.push_back(make_item(OP_TO_HZ, '1, 31'h2, '1, '0));
    todo_q.push_back(make_item(OP_TO_COORD, '0, '0, '0, 63'h1f));

    // error: illegal symbol in use, then an empty string
    tbl[AXIS_W*2 +: AXIS_W] = AXIS_INVALID;
    load_table(tbl, 5);
    todo_q.push_back(make_item(OP_TO_HZ, '1, '1, '1, '1));
    todo_q.push_back(make_item(OP_TO_COORD, '1, '1, '1, '1));
    load_table(fill_table(TBL_CYCLIC), 0);
    todo_q.push_back(make_item(OP_TO_HZ, '1, '1, '1, '1));
    todo_q.push_back(make_item(OP_TO_COORD, '1, '1, '1, '1));

    // random strings, lengths and traffic
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = 1;
        2: len = MAX_SYMS;
        3: len = MAX_SYMS - 1;
        default: len = $urandom_range(MAX_SYMS, 2);
      endcase
      tbl = fill_table(table_mode_t'($urandom_range(3)));
      if (len > 0 && $urandom_range(5) == 0) begin
        p = $urandom_range(len - 1, 0);
        tbl[AXIS_W*p +: AXIS_W] = AXIS_INVALID;
      end else if (len < MAX_SYMS && $urandom_range(3) == 0) begin
        p = $urandom_range(MAX_SYMS - 1, len);
        tbl[AXIS_W*p +: AXIS_W] = AXIS_INVALID;
      end
      load_table(tbl, len);
      case ($urandom_range(3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 5;
        2: in_idle_pct = 20;
        default: in_idle_pct = 40;
      endcase
      case ($urandom_range(3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 5;
        2: out_idle_pct = 20;
        default: out_idle_pct = 40;
      endcase
      if (ph >= PHASES - 2) calm = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++)
        todo_q.push_back(make_item(opcode_t'($urandom_range(1)), rand_coord(),
                                   rand_coord(), rand_coord(), rand_hz(len)));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
